[hw/rtl/flite_pkg.sv]
// ----------------------------------------------------------------------------
// flite_pkg
// Shared constants, widths and types for the flux interval tick encoder.
// ----------------------------------------------------------------------------
package flite_pkg;

  // Field widths
  localparam int IN_W    = 24;
  localparam int SCALE_W = 8;
  localparam int WORD_W  = 16;

  // Timing constants
  localparam int TICK_PERIOD_NS = 25;
  localparam int HALF_TICK   = TICK_PERIOD_NS / 2;
  localparam int MAX_WORDS   = 21;
  localparam int SCALE_MAX   = 200;
  localparam int SCALE_RESET = 100;
  localparam int PERCENT     = 100;
  localparam longint WORD_SPAN = 64'h10000;

  // Rounded tick count: (ns + half) / TICK_PERIOD_NS
  localparam int X_W = IN_W + 1;
  localparam longint MAX_TICKS = ((longint'(1) << IN_W) - 1 + HALF_TICK) / TICK_PERIOD_NS;
  localparam int TICK_W = $clog2(MAX_TICKS + 1);

  // Reciprocal for the divide by TICK_PERIOD_NS (estimate low by at most one)
  localparam longint RECIP_A = (longint'(1) << X_W) / TICK_PERIOD_NS;
  localparam int RA_W = $clog2(RECIP_A + 1);
  localparam int PA_W = X_W + RA_W;

  // Scaled product and reciprocal for the divide by PERCENT
  localparam int PROD_W = TICK_W + SCALE_W;
  localparam longint RECIP_B = (longint'(1) << PROD_W) / PERCENT;
  localparam int RB_W = $clog2(RECIP_B + 1);
  localparam int PB_W = PROD_W + RB_W;
  localparam longint SCALED_MAX = MAX_TICKS * SCALE_MAX / PERCENT;
  localparam int SCALED_W = $clog2(SCALED_MAX + 2);

  // Saturation of the word run
  localparam longint CAP = (MAX_WORDS - 1) * WORD_SPAN + WORD_SPAN - 1;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int SPAN_W = CNT_W - WORD_W;
  localparam int T_W    = (SCALED_W > CNT_W) ? SCALED_W : CNT_W;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

[hw/rtl/flite_if.sv]
// ----------------------------------------------------------------------------
// flite_if
// Valid/ready channels: interval input, word output and scale write port.
// ----------------------------------------------------------------------------
interface flite_in_if;
  logic                           valid;
  logic                           ready;
  logic [flite_pkg::IN_W-1:0]     interval_ns;

  modport source (output valid, output interval_ns, input ready);
  modport sink   (input valid, input interval_ns, output ready);
endinterface

interface flite_out_if;
  logic                           valid;
  logic                           ready;
  logic [flite_pkg::WORD_W-1:0]   flux_word;
  logic                           last_word;

  modport source (output valid, output flux_word, output last_word, input ready);
  modport sink   (input valid, input flux_word, input last_word, output ready);
endinterface

interface flite_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [flite_pkg::SCALE_W-1:0]  scale_percent;

  modport source (output valid, output scale_percent, input ready);
  modport sink   (input valid, input scale_percent, output ready);
endinterface

[hw/rtl/flite_front.sv]
// ----------------------------------------------------------------------------
// flite_front
// Accepts intervals, converts to rounded ticks, scales, forces odd, clamps.
// Five-stage pipeline with per-stage stall; divides use reciprocal multiply.
// ----------------------------------------------------------------------------
module flite_front (
  input  logic                          clk,
  input  logic                          rst_n,
  flite_in_if.sink                      in_if,
  flite_cfg_if.sink                     cfg_if,
  input  flite_pkg::fifo_stat_t         q_stat,
  output logic                          push,
  output logic [flite_pkg::CNT_W-1:0]   push_data
);

  // scale register
  logic [flite_pkg::SCALE_W-1:0] scale_r;

  // pipeline registers
  logic                           v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [flite_pkg::X_W-1:0]      x1_r, x2_r;
  logic [flite_pkg::SCALE_W-1:0]  sc1_r, sc2_r, sc3_r;
  logic [flite_pkg::TICK_W-1:0]   qe_r, q3_r;
  logic [flite_pkg::PROD_W-1:0]   m4_r, m5_r;
  logic [flite_pkg::SCALED_W-1:0] qe2_r;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [flite_pkg::SCALE_W-1:0]  sc_sat;
  logic [flite_pkg::PA_W-1:0]     prod_a;
  logic [flite_pkg::X_W-1:0]      rem_a;
  logic [flite_pkg::TICK_W-1:0]   q_fix;
  logic [flite_pkg::PROD_W-1:0]   m_prod;
  logic [flite_pkg::PB_W-1:0]     prod_b;
  logic [flite_pkg::PROD_W-1:0]   rem_b;
  logic [flite_pkg::SCALED_W-1:0] q2_fix;
  logic [flite_pkg::T_W-1:0]      odd_t;
  logic [flite_pkg::T_W-1:0]      clamp_t;

  // config write, always accepted
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= flite_pkg::SCALE_W'(flite_pkg::SCALE_RESET);
    end else if (cfg_if.valid) begin
      scale_r <= cfg_if.scale_percent;
    end
  end

  // stall chain: a stage loads when empty or its successor moves
  assign rdy5 = !v5_r || !q_stat.full;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_if.ready = rdy1;

  // saturate scale at the maximum percentage
  assign sc_sat = (scale_r > flite_pkg::SCALE_W'(flite_pkg::SCALE_MAX)) ?
                  flite_pkg::SCALE_W'(flite_pkg::SCALE_MAX) : scale_r;

  // tick estimate: floor(x * RECIP_A / 2^X_W)
  assign prod_a = flite_pkg::PA_W'(x1_r) * flite_pkg::PA_W'(flite_pkg::RECIP_A);

  // one-step correction of the tick estimate
  assign rem_a = x2_r - flite_pkg::X_W'(flite_pkg::X_W'(qe_r) *
                                         flite_pkg::X_W'(flite_pkg::TICK_PERIOD_NS));
  assign q_fix = (rem_a >= flite_pkg::X_W'(flite_pkg::TICK_PERIOD_NS)) ?
                 qe_r + flite_pkg::TICK_W'(1) : qe_r;

  // scale multiply
  assign m_prod = flite_pkg::PROD_W'(q3_r) * flite_pkg::PROD_W'(sc3_r);

  // percent estimate: floor(m * RECIP_B / 2^PROD_W)
  assign prod_b = flite_pkg::PB_W'(m4_r) * flite_pkg::PB_W'(flite_pkg::RECIP_B);

  // correction, odd force and run clamp
  assign rem_b = m5_r - flite_pkg::PROD_W'(flite_pkg::PROD_W'(qe2_r) *
                                            flite_pkg::PROD_W'(flite_pkg::PERCENT));
  assign q2_fix = (rem_b >= flite_pkg::PROD_W'(flite_pkg::PERCENT)) ?
                  qe2_r + flite_pkg::SCALED_W'(1) : qe2_r;
  assign odd_t   = flite_pkg::T_W'(q2_fix) | flite_pkg::T_W'(1);
  assign clamp_t = (odd_t > flite_pkg::T_W'(flite_pkg::CAP)) ?
                   flite_pkg::T_W'(flite_pkg::CAP) : odd_t;

  assign push      = v5_r && !q_stat.full;
  assign push_data = flite_pkg::CNT_W'(clamp_t);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_if.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r  <= flite_pkg::X_W'(in_if.interval_ns) + flite_pkg::X_W'(flite_pkg::HALF_TICK);
      sc1_r <= sc_sat;
    end
    if (rdy2) begin
      qe_r  <= prod_a[flite_pkg::X_W +: flite_pkg::TICK_W];
      x2_r  <= x1_r;
      sc2_r <= sc1_r;
    end
    if (rdy3) begin
      q3_r  <= q_fix;
      sc3_r <= sc2_r;
    end
    if (rdy4) begin
      m4_r <= m_prod;
    end
    if (rdy5) begin
      qe2_r <= prod_b[flite_pkg::PROD_W +: flite_pkg::SCALED_W];
      m5_r  <= m4_r;
    end
  end

endmodule

[hw/rtl/flite_fifo.sv]
// ----------------------------------------------------------------------------
// flite_fifo
// Small queue of clamped tick counts between the front and back parts.
// ----------------------------------------------------------------------------
module flite_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [flite_pkg::CNT_W-1:0]   push_data,
  input  logic                          pop,
  output logic [flite_pkg::CNT_W-1:0]   pop_data,
  output flite_pkg::fifo_stat_t         stat
);

  logic [flite_pkg::CNT_W-1:0]   mem_r [flite_pkg::FIFO_DEPTH];
  logic [flite_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [flite_pkg::FIFO_CW-1:0] count_r;

  assign stat.full  = (count_r == flite_pkg::FIFO_CW'(flite_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + flite_pkg::FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + flite_pkg::FIFO_AW'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + flite_pkg::FIFO_CW'(1);
        2'b01:   count_r <= count_r - flite_pkg::FIFO_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hw/rtl/flite_back.sv]
// ----------------------------------------------------------------------------
// flite_back
// Expands a clamped tick count into zero overflow words and a final word.
// ----------------------------------------------------------------------------
module flite_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  flite_pkg::fifo_stat_t         q_stat,
  input  logic [flite_pkg::CNT_W-1:0]   pop_data,
  output logic                          pop,
  flite_out_if.source                   out_if
);

  flite_pkg::back_state_t state_r, state_nxt;

  logic [flite_pkg::SPAN_W-1:0] spans_r, spans_nxt;
  logic [flite_pkg::WORD_W-1:0] low_r, low_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [flite_pkg::WORD_W-1:0] word_r, word_nxt;
  logic                         last_r, last_nxt;
  logic                         out_free;

  assign out_free      = !out_valid_r || out_if.ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.flux_word = word_r;
  assign out_if.last_word = last_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flite_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spans_r <= spans_nxt;
    low_r   <= low_nxt;
    word_r  <= word_nxt;
    last_r  <= last_nxt;
  end

  // next state: load a count, then one word per free output slot
  always_comb begin
    state_nxt     = state_r;
    spans_nxt     = spans_r;
    low_nxt       = low_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    pop           = 1'b0;
    unique case (state_r)
      flite_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          spans_nxt = pop_data[flite_pkg::CNT_W-1:flite_pkg::WORD_W];
          low_nxt   = pop_data[flite_pkg::WORD_W-1:0];
          state_nxt = flite_pkg::BK_EMIT;
        end
      end
      flite_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (spans_r != '0) begin
            word_nxt  = '0;
            last_nxt  = 1'b0;
            spans_nxt = spans_r - flite_pkg::SPAN_W'(1);
          end else begin
            word_nxt  = low_r;
            last_nxt  = 1'b1;
            state_nxt = flite_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = flite_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/flux_interval_tick_encoder_top.sv]
// Path: once an interval request is accepted, its first word passes pipeline stages
//   2-5, the queue, the word-expander load and the output register.
// Throughput: the word expander loads one count, then emits one word a cycle while
//   the output register is free; it loads the next count only once the final word is out.
// Reset: synchronous, active low; empties pipeline and queue, scale_percent = 100.
// ----------------------------------------------------------------------------
// flux_interval_tick_encoder_top
// Flux interval to tick-word encoder: arithmetic front, queue, word back end.
// ----------------------------------------------------------------------------
module flux_interval_tick_encoder_top (
  input  logic         clk,
  input  logic         rst_n,
  flite_in_if.sink     in_if,
  flite_cfg_if.sink    cfg_if,
  flite_out_if.source  out_if
);

  flite_pkg::fifo_stat_t         q_stat;
  logic                          push;
  logic [flite_pkg::CNT_W-1:0]   push_data;
  logic                          pop;
  logic [flite_pkg::CNT_W-1:0]   pop_data;

  // tick conversion pipeline
  flite_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_if    (cfg_if),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // count queue
  flite_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // word expander
  flite_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule

[sim/flite_word_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flite_word_checker
// Watches the interval, word and scale channels of the tick encoder. For each
// accepted interval it computes the expected word run at the current scale,
// then compares every accepted word in order against that run.
// ----------------------------------------------------------------------------
module flite_word_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [flite_pkg::IN_W-1:0]    in_interval_ns,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [flite_pkg::WORD_W-1:0]  out_flux_word,
  input  logic                          out_last_word,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [flite_pkg::SCALE_W-1:0] cfg_scale_percent,
  output int                            fail_cnt,
  output int                            pending_cnt,
  output int                            intervals_seen,
  output int                            words_seen,
  output int                            longest_run
);

  // Encoding rules, kept separate from the design's own package constants
  localparam longint unsigned TICK_NS    = 25;
  localparam longint unsigned ROUND_NS   = TICK_NS / 2;
  localparam longint unsigned SCALE_CEIL = 200;
  localparam longint unsigned PCT        = 100;
  localparam longint unsigned SPAN       = 65536;
  localparam int              RUN_MAX    = 21;
  localparam longint unsigned RUN_CAP    = (RUN_MAX - 1) * SPAN + SPAN - 1;
  localparam logic [flite_pkg::SCALE_W-1:0] SCALE_AT_RESET = 8'd100;
  localparam int              SHOW_MAX   = 10;

  typedef struct packed {
    logic [flite_pkg::WORD_W-1:0] word;
    logic                         last;
  } flux_word_t;

  flux_word_t                    expected_words[$];
  logic [flite_pkg::SCALE_W-1:0] scale_q = SCALE_AT_RESET;
  int                            fails = 0;
  int                            n_intervals = 0;
  int                            n_words = 0;
  int                            max_run = 0;
  int                            n_pending = 0;

  assign fail_cnt       = fails;
  assign pending_cnt    = n_pending;
  assign intervals_seen = n_intervals;
  assign words_seen     = n_words;
  assign longest_run    = max_run;

  // Round to ticks, scale, force odd, clamp, then split into 64K overflow words
  function automatic void encode_interval(input logic [flite_pkg::IN_W-1:0] ns);
    longint unsigned ticks;
    longint unsigned pct;
    int              run;
    flux_word_t      w;
    pct   = (scale_q > SCALE_CEIL) ? SCALE_CEIL : longint'(scale_q);
    ticks = (longint'(ns) + ROUND_NS) / TICK_NS;
    ticks = ticks * pct / PCT;
    ticks = ticks | 64'd1;
    if (ticks > RUN_CAP)
      ticks = RUN_CAP;
    run = 1;
    while (ticks >= SPAN && run < RUN_MAX) begin
      w.word = '0;
      w.last = 1'b0;
      expected_words = {expected_words, w};
      ticks = ticks - SPAN;
      run++;
    end
    w.word = ticks[flite_pkg::WORD_W-1:0];
    w.last = 1'b1;
    expected_words = {expected_words, w};
    if (run > max_run)
      max_run = run;
  endfunction

  // Sample all three channels on the clock edge
  always @(posedge clk) begin : watch
    flux_word_t want;
    if (!rst_n) begin
      scale_q = SCALE_AT_RESET;
      expected_words.delete();
    end else begin
      // result request: compare against the oldest expectation
      if (out_valid && out_ready) begin
        n_words++;
        if (expected_words.size() == 0) begin
          fails++;
          if (fails <= SHOW_MAX)
            $display("%0t: unexpected flux word %h last %b", $realtime,
                     out_flux_word, out_last_word);
        end else begin
          want = expected_words.pop_front();
          if (want.word !== out_flux_word || want.last !== out_last_word) begin
            fails++;
            if (fails <= SHOW_MAX)
              $display("%0t: flux word mismatch: expected %h last %b, got %h last %b",
                       $realtime, want.word, want.last, out_flux_word, out_last_word);
          end
        end
      end

      // interval request: queue its word run at the scale held before this edge
      if (in_valid && in_ready) begin
        n_intervals++;
        encode_interval(in_interval_ns);
      end

      if (cfg_valid && cfg_ready)
        scale_q = cfg_scale_percent;
    end
    n_pending <= expected_words.size();
  end

endmodule

[sim/tb_flux_interval_tick_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flux_interval_tick_encoder_top
// Drives flux intervals and scale writes into the tick encoder with random
// sender and receiver stalls, a long receiver hold and drain pauses; the
// checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_flux_interval_tick_encoder_top;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_LEN    = 80;
  localparam int RAND_ITEMS  = 200;
  localparam int SETTLE_CYC  = 20;
  localparam logic [flite_pkg::IN_W-1:0] NS_MAX = {flite_pkg::IN_W{1'b1}};

  logic clk;
  logic rst_n;

  flite_in_if  in_ch ();
  flite_out_if out_ch ();
  flite_cfg_if cfg_ch ();

  int fail_cnt;
  int pending_cnt;
  int intervals_seen;
  int words_seen;
  int longest_run;

  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_req;
  int scale_writes;
  int idle_cycles;

  flux_interval_tick_encoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .cfg_if (cfg_ch),
    .out_if (out_ch)
  );

  flite_word_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_interval_ns    (in_ch.interval_ns),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_flux_word     (out_ch.flux_word),
    .out_last_word     (out_ch.last_word),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_scale_percent (cfg_ch.scale_percent),
    .fail_cnt          (fail_cnt),
    .pending_cnt       (pending_cnt),
    .intervals_seen    (intervals_seen),
    .words_seen        (words_seen),
    .longest_run       (longest_run)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold when requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: cycles with no request on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no request for %0d cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one interval, with an optional gap before it
  task automatic send_interval(input logic [flite_pkg::IN_W-1:0] ns);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.interval_ns <= ns;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every expected word has come out
  task automatic drain_words();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // Scale write, only with the block empty
  task automatic write_scale(input logic [flite_pkg::SCALE_W-1:0] pct);
    drain_words();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.scale_percent <= pct;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    scale_writes++;
  endtask

  // Mix of short intervals, rounding edges, full range and 64K boundaries
  function automatic logic [flite_pkg::IN_W-1:0] pick_interval();
    int unsigned     sel;
    longint unsigned v;
    sel = $urandom_range(99);
    if (sel < 40)
      v = 64'($urandom_range(30000));
    else if (sel < 60)
      v = longint'($urandom_range(671088)) * 25 + 12 + $urandom_range(1);
    else if (sel < 85)
      v = 64'($urandom() & NS_MAX);
    else
      v = (longint'($urandom_range(1, 10)) * 65536 - 2 + $urandom_range(3)) * 25
          - 12 + $urandom_range(24);
    if (v > NS_MAX)
      v = NS_MAX;
    return v[flite_pkg::IN_W-1:0];
  endfunction

  function automatic logic [flite_pkg::SCALE_W-1:0] pick_scale();
    logic [flite_pkg::SCALE_W-1:0] corner [7];
    corner = '{8'd0, 8'd1, 8'd99, 8'd100, 8'd200, 8'd201, 8'd255};
    if ($urandom_range(1) == 0)
      return corner[$urandom_range(6)];
    return flite_pkg::SCALE_W'($urandom_range(255));
  endfunction

  // Stimulus
  initial begin
    logic [flite_pkg::IN_W-1:0] at_reset_scale [13];
    at_reset_scale = '{24'd0, 24'd1, 24'd12, 24'd13, 24'd37, 24'd38,
                       24'd1638375, 24'd1638387, 24'd1638388, 24'd3276800,
                       24'h555555, 24'hAAAAAA, NS_MAX};

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.interval_ns    <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.scale_percent <= '0;
    hold_req             <= 1'b0;
    tx_idle_pct          = 18;
    rx_idle_pct          <= 46;
    scale_writes         = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: rounding edges and 64K boundaries at the reset scale
    foreach (at_reset_scale[i])
      send_interval(at_reset_scale[i]);

    // Scale of zero always yields a single word of one
    write_scale(8'd0);
    send_interval(NS_MAX);
    send_interval(24'd0);
    // Scales above the ceiling behave as the ceiling; longest run
    write_scale(8'd255);
    send_interval(NS_MAX);
    send_interval(24'd1638400);
    write_scale(8'd201);
    send_interval(NS_MAX);
    write_scale(8'd1);
    send_interval(NS_MAX);
    send_interval(24'd2475);
    write_scale(8'd200);
    send_interval(NS_MAX);

    // Random: three idle profiles, new scale every 25 intervals
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        tx_idle_pct = 46;
        rx_idle_pct <= 18;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (i % 25 == 0)
        write_scale(pick_scale());
      // long receiver hold while intervals keep coming
      if ((i == 10 || i == 90) && !hold_req)
        hold_req <= 1'b1;
      send_interval(pick_interval());
    end

    drain_words();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Covered %0d intervals and %0d words over %0d scale writes,", intervals_seen,
             words_seen, scale_writes);
    $display("longest run %0d words, including zero and saturated scales.", longest_run);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Failures: %0d, words still expected: %0d", fail_cnt, pending_cnt);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
